// ----- hdl/cdc_pkg.sv -----
package cdc_pkg;

   // field widths
   localparam int FREQ_W = 28;
   localparam int XTAL_W = 26;
   localparam int P1_W   = 18;
   localparam int P2_W   = 20;

   // frequency limits and crystal register reset
   localparam logic [FREQ_W-1:0] FREQ_MIN   = 28'd1000000;
   localparam logic [FREQ_W-1:0] FREQ_MAX   = 28'd150000000;
   localparam logic [XTAL_W-1:0] XTAL_MIN   = 26'd10000000;
   localparam logic [XTAL_W-1:0] XTAL_MAX   = 26'd40000000;
   localparam logic [XTAL_W-1:0] XTAL_RESET = 26'd25000000;

   // output divider: floor(VCO_MAX / f), 10 quotient bits
   localparam logic [29:0] VCO_MAX   = 30'd900000000;
   localparam int          DIVA_BITS = 10;
   localparam logic [19:0] DIVA_HI   = VCO_MAX[29:10];
   localparam logic [9:0]  DIVA_LO   = VCO_MAX[9:0];
   // multiplier: floor(pll / xtal), 8 quotient bits
   localparam int          DIVB_BITS = 8;
   // fraction numerator: 20 quotient bits
   localparam int          DIVC_BITS = 20;
   // two quotient bits per divider step
   localparam logic [3:0]  DIVA_STEPS = 4'(DIVA_BITS / 2);
   localparam logic [3:0]  DIVB_STEPS = 4'(DIVB_BITS / 2);
   localparam logic [3:0]  DIVC_STEPS = 4'(DIVC_BITS / 2);

   localparam logic [P2_W-1:0] FRAC_DENOM = 20'd1048575;
   localparam logic [P2_W-1:0] MS_P3      = 20'd1;
   localparam logic [P1_W-1:0] P1_OFFSET  = 18'd512;

   // register map
   localparam logic [7:0] PLLA_BASE    = 8'd26;
   localparam logic [7:0] PLLB_BASE    = 8'd34;
   localparam logic [7:0] MSA_BASE     = 8'd42;
   localparam logic [7:0] MSB_BASE     = 8'd58;
   localparam logic [7:0] CLK0_CTL     = 8'd16;
   localparam logic [7:0] CLK2_CTL     = 8'd18;
   localparam logic [7:0] PLL_RST_ADDR = 8'd177;
   localparam logic [7:0] PLL_RST_DATA = 8'hA0;
   localparam logic [7:0] CLK_ON_BITS  = 8'h4F;
   localparam logic [7:0] CLK_SRC_PLLB = 8'h20;

   // write sequence positions
   localparam logic [4:0] IDX_EXTRA = 5'd16;
   localparam logic [4:0] IDX_LAST  = 5'd17;

   typedef enum logic {
      CH_A,
      CH_B
   } chan_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_DIVA,
      F_MUL,
      F_DIVB,
      F_PREP,
      F_DIVC,
      F_DONE
   } front_state_type;

   // one computed request, front to back
   typedef struct packed {
      chan_type        chan;
      logic            rst;
      logic [P1_W-1:0] pll_p1;
      logic [P2_W-1:0] pll_p2;
      logic [P1_W-1:0] ms_p1;
   } job_type;

endpackage

// ----- hdl/cdc_front.sv -----
module cdc_front
   import cdc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [XTAL_W-1:0] csr_wdata,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [FREQ_W-1:0] target_freq,
   input  chan_type          chan,
   input  logic              reset_pll,
   output logic              q_valid,
   input  logic              q_ready,
   output job_type           q_job
);

   front_state_type state_ff, state_in;
   logic [XTAL_W-1:0] crystal_ff;
   logic [3:0]        cnt_ff, cnt_in;
   logic [27:0]       rem_ff, rem_in;
   logic [27:0]       den_ff, den_in;
   logic [19:0]       shf_ff, shf_in;
   logic [19:0]       quo_ff, quo_in;
   chan_type          chan_ff, chan_in;
   logic              rst_ff, rst_in;
   logic [9:0]        div_ff, div_in;
   logic [6:0]        mult_ff, mult_in;

   logic [FREQ_W-1:0] f_clamp;
   logic [XTAL_W-1:0] xtal_clamp;
   logic [28:0]       t1, t2, d1, d2;
   logic              ge1, ge2;
   logic [27:0]       r1, r2;
   logic [9:0]        div_even;
   logic [37:0]       prod;
   logic [45:0]       dprod;
   logic [6:0]        q0;
   logic [20:0]       frac_sum, frac_sub;
   logic              frac_ge;
   logic [7:0]        q_fix;

   // crystal register
   always_ff @(posedge clock) begin
      if (reset) begin
         crystal_ff <= XTAL_RESET;
      end else if (csr_we) begin
         crystal_ff <= csr_wdata;
      end
   end

   // input clamps
   always_comb begin
      if (target_freq < FREQ_MIN) begin
         f_clamp = FREQ_MIN;
      end else if (target_freq > FREQ_MAX) begin
         f_clamp = FREQ_MAX;
      end else begin
         f_clamp = target_freq;
      end
      if (crystal_ff < XTAL_MIN) begin
         xtal_clamp = XTAL_MIN;
      end else if (crystal_ff > XTAL_MAX) begin
         xtal_clamp = XTAL_MAX;
      end else begin
         xtal_clamp = crystal_ff;
      end
   end

   // shared divider: two restoring steps per cycle
   assign t1  = {rem_ff, shf_ff[19]};
   assign d1  = t1 - {1'b0, den_ff};
   assign ge1 = (t1 >= {1'b0, den_ff});
   assign r1  = ge1 ? d1[27:0] : t1[27:0];
   assign t2  = {r1, shf_ff[18]};
   assign d2  = t2 - {1'b0, den_ff};
   assign ge2 = (t2 >= {1'b0, den_ff});
   assign r2  = ge2 ? d2[27:0] : t2[27:0];

   // pll frequency = even divider * f (den holds f here)
   assign div_even = {quo_ff[9:1], 1'b0};
   assign prod     = {28'd0, div_even} * {10'd0, den_ff};

   // fraction dividend = rem * (2^20 - 1)
   assign dprod = {rem_ff[25:0], 20'd0} - {20'd0, rem_ff[25:0]};

   // q = floor(num * 128 / FRAC_DENOM), p2 is the remainder
   assign q0       = quo_ff[19:13];
   assign frac_sum = {1'b0, quo_ff[12:0], 7'd0} + {14'd0, q0};
   assign frac_ge  = (frac_sum >= {1'b0, FRAC_DENOM});
   assign frac_sub = frac_sum - {1'b0, FRAC_DENOM};
   assign q_fix    = {1'b0, q0} + {7'd0, frac_ge};

   assign q_job.chan   = chan_ff;
   assign q_job.rst    = rst_ff;
   assign q_job.pll_p1 = P1_W'({mult_ff, 7'd0}) + P1_W'(q_fix) - P1_OFFSET;
   assign q_job.pll_p2 = frac_ge ? frac_sub[19:0] : frac_sum[19:0];
   assign q_job.ms_p1  = P1_W'({div_ff, 7'd0}) - P1_OFFSET;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      shf_ff  <= shf_in;
      quo_ff  <= quo_in;
      chan_ff <= chan_in;
      rst_ff  <= rst_in;
      div_ff  <= div_in;
      mult_ff <= mult_in;
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      den_in     = den_ff;
      shf_in     = shf_ff;
      quo_in     = quo_ff;
      chan_in    = chan_ff;
      rst_in     = rst_ff;
      div_in     = div_ff;
      mult_in    = mult_ff;
      req_tready = 1'b0;
      q_valid    = 1'b0;
      case (state_ff)
         F_IDLE, F_DONE: begin
            q_valid = (state_ff == F_DONE);
            if (state_ff == F_IDLE || q_ready) begin
               req_tready = 1'b1;
               state_in   = F_IDLE;
               if (req_tvalid) begin
                  chan_in  = chan;
                  rst_in   = reset_pll;
                  rem_in   = {8'd0, DIVA_HI};
                  den_in   = f_clamp;
                  shf_in   = {DIVA_LO, 10'd0};
                  quo_in   = '0;
                  cnt_in   = DIVA_STEPS;
                  state_in = F_DIVA;
               end
            end
         end
         F_DIVA, F_DIVB, F_DIVC: begin
            rem_in = r2;
            shf_in = {shf_ff[17:0], 2'b00};
            quo_in = {quo_ff[17:0], ge1, ge2};
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == 4'd1) begin
               case (state_ff)
                  F_DIVA:  state_in = F_MUL;
                  F_DIVB:  state_in = F_PREP;
                  default: state_in = F_DONE;
               endcase
            end
         end
         F_MUL: begin
            div_in   = div_even;
            rem_in   = {6'd0, prod[29:8]};
            shf_in   = {prod[7:0], 12'd0};
            den_in   = {2'd0, xtal_clamp};
            quo_in   = '0;
            cnt_in   = DIVB_STEPS;
            state_in = F_DIVB;
         end
         F_PREP: begin
            mult_in  = quo_ff[6:0];
            rem_in   = {2'd0, dprod[45:20]};
            shf_in   = dprod[19:0];
            quo_in   = '0;
            cnt_in   = DIVC_STEPS;
            state_in = F_DIVC;
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   // partial remainder stays below the divisor while dividing
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == F_DIVA || state_ff == F_DIVB || state_ff == F_DIVC)
      |-> (rem_ff < den_ff && cnt_ff != 4'd0))
      else $error("divider remainder out of range");

endmodule

// ----- hdl/cdc_fifo.sv -----
module cdc_fifo
   import cdc_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_ready,
   output job_type out_job
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type         entry_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]   cnt_ff;
   logic            push, pop;

   assign in_ready  = (cnt_ff != CW'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;
   assign out_job   = entry_ff[rd_ptr_ff];

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_job;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + CW'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(DEPTH))
      else $error("queue count overflow");

endmodule

// ----- hdl/cdc_back.sv -----
module cdc_back
   import cdc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   output logic       q_ready,
   input  job_type    q_job,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] reg_addr,
   output logic [7:0] reg_data,
   output logic       last_write
);

   logic       busy_ff;
   logic [4:0] idx_ff;
   job_type    job_ff;
   logic       out_valid_ff;
   logic [7:0] addr_ff, data_ff;
   logic       last_ff;

   logic       out_free, fire;
   logic [7:0] cur_addr, cur_data;
   logic       cur_last;

   // one byte of a P1/P2/P3 register block
   function automatic logic [7:0] word_byte(input logic [2:0]      sel,
                                            input logic [P1_W-1:0] p1,
                                            input logic [P2_W-1:0] p2,
                                            input logic [P2_W-1:0] p3);
      logic [7:0] b;
      case (sel)
         3'd0:    b = p3[15:8];
         3'd1:    b = p3[7:0];
         3'd2:    b = {6'd0, p1[17:16]};
         3'd3:    b = p1[15:8];
         3'd4:    b = p1[7:0];
         3'd5:    b = {p3[19:16], p2[19:16]};
         3'd6:    b = p2[15:8];
         3'd7:    b = p2[7:0];
         default: b = '0;
      endcase
      return b;
   endfunction

   assign out_free = !out_valid_ff || rsp_tready;
   assign fire     = busy_ff && out_free;
   assign q_ready  = !busy_ff;

   // current write of the sequence
   always_comb begin
      cur_last = 1'b0;
      if (idx_ff[4]) begin
         if (idx_ff == IDX_EXTRA && job_ff.rst) begin
            cur_addr = PLL_RST_ADDR;
            cur_data = PLL_RST_DATA;
         end else begin
            cur_addr = (job_ff.chan == CH_B) ? CLK2_CTL : CLK0_CTL;
            cur_data = CLK_ON_BITS | ((job_ff.chan == CH_B) ? CLK_SRC_PLLB : 8'd0);
            cur_last = 1'b1;
         end
      end else if (!idx_ff[3]) begin
         cur_addr = ((job_ff.chan == CH_B) ? PLLB_BASE : PLLA_BASE) + {5'd0, idx_ff[2:0]};
         cur_data = word_byte(idx_ff[2:0], job_ff.pll_p1, job_ff.pll_p2, FRAC_DENOM);
      end else begin
         cur_addr = ((job_ff.chan == CH_B) ? MSB_BASE : MSA_BASE) + {5'd0, idx_ff[2:0]};
         cur_data = word_byte(idx_ff[2:0], job_ff.ms_p1, '0, MS_P3);
      end
   end

   // sequence control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!busy_ff && q_valid) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (fire) begin
            idx_ff <= idx_ff + 5'd1;
            if (cur_last) begin
               busy_ff <= 1'b0;
            end
         end
         if (fire) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (!busy_ff && q_valid) begin
         job_ff <= q_job;
      end
      if (fire) begin
         addr_ff <= cur_addr;
         data_ff <= cur_data;
         last_ff <= cur_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign reg_addr   = addr_ff;
   assign reg_data   = data_ff;
   assign last_write = last_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff <= IDX_LAST)
      else $error("write index past end of sequence");

   a_last_is_ctl: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && last_ff) |-> (addr_ff == CLK0_CTL || addr_ff == CLK2_CTL))
      else $error("final word is not an output control write");

   a_busy_ends: assert property (@(posedge clock) disable iff (reset)
      (fire && cur_last) |=> !busy_ff)
      else $error("sequencer still busy after final word");

endmodule

// ----- hdl/clock_synth_divider_calc.sv -----
// Synthesizer divider calculator.
// req channel: one word per request; tdata carries the target frequency in
// hertz and the PLL reset flag, tuser selects PLL A / output 0 or PLL B /
// output 2. The target is clamped to 1..150 MHz, the crystal to 10..40 MHz.
// rsp channel: 17 words per request (18 with the PLL reset write), each a
// register address and data byte; tlast marks the output control write.
// csr: csr_we writes the crystal frequency register (hertz).
// The front end computes each job with the shared divider; the job then
// passes through the queue and the back end's job and output registers.
// The front end takes no new request until its job enters the queue; its
// shared divider runs 5 + 4 + 10 two-bit steps, multiply, setup, hand-off.
// The back end streams one word per cycle while rsp_tready is high, 17 or
// 18 per job after loading it, as the front end works on the next request.
// Reset: crystal register returns to 25 MHz, queue and sequencer empty.
// A stalled rsp_tready holds the output register; the queue then fills and
// req_tready drops until words drain.
module clock_synth_divider_calc
   import cdc_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  logic              clock,
   input  logic              reset,
   // configuration
   input  logic              csr_we,
   input  logic [XTAL_W-1:0] csr_wdata,     // crystal_freq
   // request channel
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,     // [27:0] target_freq, [28] reset_pll
   input  logic              req_tuser,     // [0] channel
   // response channel
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [15:0]       rsp_tdata,     // [7:0] reg_addr, [15:8] reg_data
   output logic              rsp_tlast      // last_write
);

   logic    fq_valid, fq_ready, bq_valid, bq_ready;
   job_type fq_job, bq_job;
   logic [7:0] reg_addr, reg_data;

   cdc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .target_freq (req_tdata[FREQ_W-1:0]),
      .chan        (chan_type'(req_tuser)),
      .reset_pll   (req_tdata[FREQ_W]),
      .q_valid     (fq_valid),
      .q_ready     (fq_ready),
      .q_job       (fq_job)
   );

   cdc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_job    (fq_job),
      .out_valid (bq_valid),
      .out_ready (bq_ready),
      .out_job   (bq_job)
   );

   cdc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (bq_valid),
      .q_ready    (bq_ready),
      .q_job      (bq_job),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .reg_addr   (reg_addr),
      .reg_data   (reg_data),
      .last_write (rsp_tlast)
   );

   assign rsp_tdata = {reg_data, reg_addr};

endmodule

// ----- tb/synth_write_checker.sv -----
`timescale 1ns / 100ps

// Watches the request, response and csr channels of the divider calculator,
// predicts the register write sequence of every accepted request and checks
// each response word against the oldest predicted write.
module synth_write_checker
   import cdc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [XTAL_W-1:0] csr_wdata,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [31:0]       req_tdata,     // [27:0] target_freq, [28] reset_pll
   input  logic              req_tuser,     // [0] channel
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [15:0]       rsp_tdata,     // [7:0] reg_addr, [15:8] reg_data
   input  logic              rsp_tlast,     // last_write
   output int                mismatch_count,
   output int                writes_pending,
   output int                writes_checked
);

   // keep the log readable when the block is badly broken
   localparam int PRINT_CAP = 40;

   typedef struct packed {
      logic [7:0] addr;
      logic [7:0] data;
      logic       last;
   } synth_write_type;

   synth_write_type   write_q[$];
   logic [XTAL_W-1:0] crystal_reg;

   initial begin
      mismatch_count = 0;
      writes_pending = 0;
      writes_checked = 0;
      crystal_reg    = XTAL_RESET;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) begin
         $display("%0t ns: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
      end
   endtask

   function automatic void add_write(input logic [7:0] addr, input logic [7:0] data,
                                     input logic last);
      write_q.push_back('{addr: addr, data: data, last: last});
   endfunction

   // eight bytes of one P1/P2/P3 parameter group, R divider field zero
   function automatic void add_group(input logic [7:0] base, input logic [31:0] p1,
                                     input logic [31:0] p2, input logic [31:0] p3);
      add_write(base,        p3[15:8],              1'b0);
      add_write(base + 8'd1, p3[7:0],               1'b0);
      add_write(base + 8'd2, {6'b000000, p1[17:16]}, 1'b0);
      add_write(base + 8'd3, p1[15:8],              1'b0);
      add_write(base + 8'd4, p1[7:0],               1'b0);
      add_write(base + 8'd5, {p3[19:16], p2[19:16]}, 1'b0);
      add_write(base + 8'd6, p2[15:8],              1'b0);
      add_write(base + 8'd7, p2[7:0],               1'b0);
   endfunction

   // divider, PLL multiplier and fraction, then the full write sequence
   function automatic void predict_request(input logic [FREQ_W-1:0] target,
                                           input chan_type chan, input logic pll_reset,
                                           input logic [XTAL_W-1:0] xtal_setting);
      logic [31:0] f;
      logic [31:0] xtal;
      logic [31:0] divider;
      logic [31:0] vco;
      logic [31:0] mult;
      logic [31:0] rem;
      logic [31:0] num;
      logic [31:0] q;
      logic [31:0] pll_p1;
      logic [31:0] pll_p2;
      logic [31:0] ms_p1;
      logic [7:0]  pll_base;
      logic [7:0]  ms_base;
      logic [7:0]  ctl_addr;
      logic [7:0]  ctl_src;
      f    = 32'(target);
      xtal = 32'(xtal_setting);
      // clamp target and crystal to their legal ranges
      if (f < 32'(FREQ_MIN)) f = 32'(FREQ_MIN);
      if (f > 32'(FREQ_MAX)) f = 32'(FREQ_MAX);
      if (xtal < 32'(XTAL_MIN)) xtal = 32'(XTAL_MIN);
      if (xtal > 32'(XTAL_MAX)) xtal = 32'(XTAL_MAX);
      // even output divider and resulting VCO frequency
      divider    = 32'(VCO_MAX) / f;
      divider[0] = 1'b0;
      vco        = divider * f;
      // multiplier a + b/c with c fixed at the fraction denominator
      mult   = vco / xtal;
      rem    = vco % xtal;
      num    = 32'((64'(rem) * 64'(FRAC_DENOM)) / 64'(xtal));
      q      = 32'((64'(num) << 7) / 64'(FRAC_DENOM));
      pll_p1 = (mult << 7) + q - 32'(P1_OFFSET);
      pll_p2 = (num << 7) - 32'(FRAC_DENOM) * q;
      ms_p1  = (divider << 7) - 32'(P1_OFFSET);
      if (chan == CH_A) begin
         pll_base = PLLA_BASE;
         ms_base  = MSA_BASE;
         ctl_addr = CLK0_CTL;
         ctl_src  = 8'h00;
      end else begin
         pll_base = PLLB_BASE;
         ms_base  = MSB_BASE;
         ctl_addr = CLK2_CTL;
         ctl_src  = CLK_SRC_PLLB;
      end
      add_group(pll_base, pll_p1, pll_p2, 32'(FRAC_DENOM));
      add_group(ms_base, ms_p1, 32'd0, 32'(MS_P3));
      if (pll_reset) add_write(PLL_RST_ADDR, PLL_RST_DATA, 1'b0);
      add_write(ctl_addr, CLK_ON_BITS | ctl_src, 1'b1);
   endfunction

   // track csr writes, predict on request words, compare response words
   always @(posedge clock) begin
      synth_write_type want;
      if (reset) begin
         crystal_reg = XTAL_RESET;
         write_q.delete();
      end else begin
         if (csr_we) crystal_reg = csr_wdata;
         if (req_tvalid && req_tready) begin
            predict_request(req_tdata[FREQ_W-1:0], chan_type'(req_tuser),
                            req_tdata[FREQ_W], crystal_reg);
         end
         if (rsp_tvalid && rsp_tready) begin
            writes_checked++;
            if (write_q.size() == 0) begin
               report_mismatch("unexpected word", int'(rsp_tdata), 0);
            end else begin
               want = write_q.pop_front();
               if (rsp_tdata[7:0] != want.addr)
                  report_mismatch("reg_addr", rsp_tdata[7:0], want.addr);
               if (rsp_tdata[15:8] != want.data)
                  report_mismatch($sformatf("reg_data @%0d", want.addr),
                                  rsp_tdata[15:8], want.data);
               if (rsp_tlast != want.last)
                  report_mismatch($sformatf("last_write @%0d", want.addr),
                                  rsp_tlast, want.last);
            end
         end
      end
      writes_pending <= write_q.size();
   end

endmodule

// ----- tb/tb_clock_synth_divider_calc.sv -----
`timescale 1ns / 100ps

module tb_clock_synth_divider_calc;
   import cdc_pkg::*;

   localparam int NUM_SETTINGS    = 7;
   localparam int ITEMS_PER_PHASE = 13;
   localparam int HOLD_PHASE      = 2;
   localparam int PAUSE_PHASE     = 4;
   localparam int LONG_HOLD       = 400;
   localparam int DRAIN_CYCLES    = 40;
   localparam int CYCLE_LIMIT     = 200000;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [XTAL_W-1:0] csr_wdata;
   logic              req_tvalid;
   logic              req_tready;
   logic [31:0]       req_tdata;     // [27:0] target_freq, [28] reset_pll
   logic              req_tuser;     // [0] channel
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [15:0]       rsp_tdata;     // [7:0] reg_addr, [15:8] reg_data
   logic              rsp_tlast;     // last_write

   int mismatch_count;
   int writes_pending;
   int writes_checked;
   int requests_sent;
   int settings_used;
   int hold_requests;
   int cycle_count;

   clock_synth_divider_calc i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   synth_write_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .writes_pending (writes_pending),
      .writes_checked (writes_checked)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d writes still expected",
                  cycle_count, writes_pending);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver: stall patterns of random length and density, one long hold-off
   initial begin : rsp_side
      int unsigned stall_pct;
      int          pattern_left;
      int          hold_cycles;
      int          holds_seen;
      stall_pct    = 0;
      pattern_left = 0;
      holds_seen   = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_seen) begin
            holds_seen = hold_requests;
            rsp_tready <= 1'b0;
            for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++) @(posedge clock);
         end else begin
            if (pattern_left == 0) begin
               pattern_left = $urandom_range(8, 60);
               case ($urandom_range(0, 3))
                  0: stall_pct = 0;
                  1: stall_pct = 20;
                  2: stall_pct = 50;
                  default: stall_pct = 85;
               endcase
            end
            pattern_left--;
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // target mix: mostly in range, some near divider steps, some clamped
   function automatic logic [FREQ_W-1:0] pick_target();
      int unsigned sel;
      int unsigned div_even;
      sel      = $urandom_range(0, 9);
      div_even = 2 * $urandom_range(3, 450);
      case (sel)
         0, 1, 2, 3, 4: return FREQ_W'($urandom_range(FREQ_MIN, FREQ_MAX));
         5, 6:          return FREQ_W'(32'(VCO_MAX) / div_even + $urandom_range(0, 4) - 2);
         7:             return FREQ_W'($urandom);
         8:             return FREQ_W'($urandom_range(0, FREQ_MIN));
         default:       return FREQ_W'($urandom_range(FREQ_MAX, {FREQ_W{1'b1}}));
      endcase
   endfunction

   // offer one request word and hold it until accepted
   task automatic send_request(input logic [FREQ_W-1:0] target, input chan_type chan,
                               input logic pll_reset);
      req_tdata  <= {3'b000, pll_reset, target};
      req_tuser  <= chan;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      requests_sent++;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (writes_pending != 0);
   endtask

   task automatic write_crystal(input logic [XTAL_W-1:0] value);
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      settings_used++;
   endtask

   // random requests in bursts; steady means back to back with no gaps
   task automatic run_random(input int count, input bit steady, input bit pause_midway);
      int burst_left;
      int gap;
      int n;
      burst_left = 0;
      for (n = 0; n < count; n++) begin
         if (pause_midway && n == count / 2) begin
            req_tvalid <= 1'b0;
            wait_drained();
            burst_left = $urandom_range(1, 6);
         end else if (!steady && burst_left <= 0) begin
            burst_left = $urandom_range(1, 6);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         send_request(pick_target(), chan_type'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
         burst_left--;
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin : stimulus
      logic [XTAL_W-1:0] crystal_plan [NUM_SETTINGS];
      int                ph;
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = 1'b0;
      rsp_tready    = 1'b0;
      requests_sent = 0;
      settings_used = 1;
      hold_requests = 0;
      cycle_count   = 0;

      crystal_plan[0] = XTAL_MIN;
      crystal_plan[1] = XTAL_MAX;
      crystal_plan[2] = '0;
      crystal_plan[3] = '1;
      crystal_plan[4] = XTAL_W'($urandom_range(XTAL_MIN, XTAL_MAX));
      crystal_plan[5] = XTAL_W'($urandom);
      crystal_plan[6] = 26'd27000000;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words at the reset crystal: clamps, field extremes,
      // divider steps and a VCO that is an exact multiple of the crystal
      send_request(28'd0,                CH_A, 1'b0);
      send_request(28'hFFFFFFF,          CH_B, 1'b1);
      send_request(FREQ_MIN - 28'd1,     CH_A, 1'b1);
      send_request(FREQ_MIN,             CH_B, 1'b0);
      send_request(FREQ_MIN + 28'd1,     CH_A, 1'b0);
      send_request(FREQ_MAX,             CH_B, 1'b1);
      send_request(FREQ_MAX + 28'd1,     CH_A, 1'b1);
      send_request(FREQ_MAX - 28'd1,     CH_B, 1'b0);
      send_request(28'd25000000,         CH_A, 1'b0);
      send_request(28'd10000000,         CH_B, 1'b1);
      send_request(28'd128571428,        CH_A, 1'b1);
      send_request(28'd128571429,        CH_B, 1'b0);
      send_request(28'd112500000,        CH_A, 1'b0);
      send_request(28'd112499999,        CH_B, 1'b1);
      send_request(28'd14318180,         CH_A, 1'b1);
      send_request(28'd7372800,          CH_B, 1'b0);
      send_request(28'd3579545,          CH_A, 1'b0);
      send_request(28'd48000000,         CH_B, 1'b1);
      send_request(28'd1234567,          CH_A, 1'b1);
      send_request(28'd99999999,         CH_B, 1'b0);
      req_tvalid <= 1'b0;

      // one crystal setting per phase, written only with the block drained
      for (ph = 0; ph < NUM_SETTINGS; ph++) begin
         wait_drained();
         write_crystal(crystal_plan[ph]);
         if (ph == HOLD_PHASE) begin
            // receiver holds off while words keep coming, filling the queue
            hold_requests <= hold_requests + 1;
            run_random(ITEMS_PER_PHASE, 1'b1, 1'b0);
         end else begin
            run_random(ITEMS_PER_PHASE, 1'b0, ph == PAUSE_PHASE);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d requests on both channels, with and without PLL reset,",
               requests_sent);
      $display("clamped targets and %0d crystal settings; %0d register writes checked.",
               settings_used, writes_checked);
      if (mismatch_count == 0 && writes_pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
